[rtl/harris_corner_detector_unit_defines.svh]
// ----------------------------------------------------------------------------
// harris corner detector assertion macros
// concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef HARRIS_CORNER_DETECTOR_UNIT_DEFINES_SVH
`define HARRIS_CORNER_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define HCD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define HCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hcd_pkg.sv]
// ----------------------------------------------------------------------------
// hcd_pkg
// shared types, constants and helpers of the harris corner detector
// ----------------------------------------------------------------------------
package hcd_pkg;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 1024;
  localparam int THRESHOLD_RESET = 30000;
  localparam int WIDTH_RESET     = 640;
  localparam int HEIGHT_RESET    = 480;
  localparam int RESP_SCALE      = 25;
  localparam int MIN_SIZE        = 3;

  localparam int CFG_DATA_W   = 17;
  localparam int CFG_INDEX_W  = 2;
  localparam int FRAME_SIZE_W = 11;
  localparam int THR25_W      = 22;

  localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT    = 2'd2;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] gray_pixel;
  } in_item_t;

  typedef struct packed {
    logic is_corner;
    logic end_of_frame;
  } out_item_t;

  // window position flags of one step
  typedef struct packed {
    logic valid;
    logic col_first;
    logic col_second;
    logic row_top;
    logic row_bottom;
  } win_ctl_t;

  typedef struct packed {
    logic valid;
    logic eof;
  } res_ctl_t;

  typedef struct packed {
    logic [7:0] t;
    logic [7:0] m;
    logic [7:0] b;
  } gray_col_t;

  typedef struct packed {
    logic [15:0] xx;
    logic [15:0] yy;
    logic [15:0] xy;
  } prod_t;

  typedef struct packed {
    logic [17:0] xx;
    logic [17:0] yy;
    logic [17:0] xy;
  } vsum_t;

  typedef struct packed {
    logic [7:0] xx;
    logic [7:0] yy;
    logic [7:0] xy;
  } smooth_t;

  function automatic int clamp_size(input int v, input int maxv);
    int r;
    r = v;
    if (r < MIN_SIZE) r = MIN_SIZE;
    if (r > maxv) r = maxv;
    return r;
  endfunction

  function automatic logic [7:0] sat_abs(input logic signed [10:0] v);
    logic [10:0] m;
    m = v[10] ? 11'(-v) : 11'(v);
    return (m > 11'd255) ? 8'hFF : m[7:0];
  endfunction

  function automatic logic [7:0] round_sat(input logic [19:0] s);
    logic [19:0] t;
    t = s + 20'd8;
    return (t[19:4] > 16'd255) ? 8'hFF : t[11:4];
  endfunction

endpackage

[rtl/hcd_gradient.sv]
// ----------------------------------------------------------------------------
// hcd_gradient
// gray line memory, 3x3 reflected window, sobel magnitudes and products
// ----------------------------------------------------------------------------
module hcd_gradient import hcd_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  win_ctl_t                     ctl,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr,
  input  logic [7:0]                   pixel,
  output prod_t                        prod
);

  localparam int CAW = $clog2(MAX_WIDTH);

  // entry: [15:8] two rows up, [7:0] one row up
  logic [15:0]    line_mem [MAX_WIDTH];
  logic [15:0]    rd_q;
  win_ctl_t       c1;
  logic [CAW-1:0] a1;
  logic [7:0]     p1;
  gray_col_t      cur, v1, v2, lft, rgt;
  logic signed [10:0] gx, gy;
  logic [7:0]     ix, iy;

  function automatic logic signed [10:0] ext(input logic [7:0] v);
    return $signed({3'b000, v});
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_q <= line_mem[addr];
      if (c1.valid) begin
        line_mem[a1] <= {rd_q[7:0], p1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
    end else if (adv) begin
      c1 <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1 <= addr;
      p1 <= pixel;
    end
  end

  // column vector with vertical reflection
  always_comb begin
    cur.t = c1.row_top ? p1 : rd_q[15:8];
    cur.m = rd_q[7:0];
    cur.b = c1.row_bottom ? rd_q[15:8] : p1;
    lft   = c1.col_second ? cur : v2;
    rgt   = c1.col_first ? v2 : cur;
    gx = (ext(rgt.t) - ext(lft.t)) + ((ext(rgt.m) - ext(lft.m)) <<< 1)
       + (ext(rgt.b) - ext(lft.b));
    gy = (ext(lft.b) - ext(lft.t)) + ((ext(v1.b) - ext(v1.t)) <<< 1)
       + (ext(rgt.b) - ext(rgt.t));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (c1.valid) begin
        v2 <= v1;
        v1 <= cur;
      end
      ix      <= sat_abs(gx);
      iy      <= sat_abs(gy);
      prod.xx <= 16'(ix) * 16'(ix);
      prod.yy <= 16'(iy) * 16'(iy);
      prod.xy <= 16'(ix) * 16'(iy);
    end
  end

endmodule

[rtl/hcd_smooth.sv]
// ----------------------------------------------------------------------------
// hcd_smooth
// product line memory and separable [1 2 1] blur with round and saturate
// ----------------------------------------------------------------------------
module hcd_smooth import hcd_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  win_ctl_t                     ctl,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr,
  input  prod_t                        prod,
  output smooth_t                      g
);

  localparam int CAW = $clog2(MAX_WIDTH);

  // entry: [95:48] two rows up, [47:0] one row up
  logic [95:0]    line_mem [MAX_WIDTH];
  logic [95:0]    rd_q;
  win_ctl_t       c1, c2, c3;
  logic [CAW-1:0] a1, a2, a3;
  prod_t          older, newer, pt, pb;
  vsum_t          cur, v1, v2, lft, rgt;

  function automatic logic [17:0] vert(input logic [15:0] t, input logic [15:0] m,
                                       input logic [15:0] b);
    return 18'(t) + (18'(m) << 1) + 18'(b);
  endfunction

  function automatic logic [7:0] horz(input logic [17:0] l, input logic [17:0] c,
                                      input logic [17:0] r);
    return round_sat(20'(l) + (20'(c) << 1) + 20'(r));
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_q <= line_mem[a2];
      if (c3.valid) begin
        line_mem[a3] <= {rd_q[47:0], prod};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
    end else if (adv) begin
      c1 <= ctl;
      c2 <= c1;
      c3 <= c2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1 <= addr;
      a2 <= a1;
      a3 <= a2;
    end
  end

  always_comb begin
    older = rd_q[95:48];
    newer = rd_q[47:0];
    pt    = c3.row_top ? prod : older;
    pb    = c3.row_bottom ? older : prod;
    cur.xx = vert(pt.xx, newer.xx, pb.xx);
    cur.yy = vert(pt.yy, newer.yy, pb.yy);
    cur.xy = vert(pt.xy, newer.xy, pb.xy);
    lft = c3.col_second ? cur : v2;
    rgt = c3.col_first ? v2 : cur;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (c3.valid) begin
        v2 <= v1;
        v1 <= cur;
      end
      g.xx <= horz(lft.xx, v1.xx, rgt.xx);
      g.yy <= horz(lft.yy, v1.yy, rgt.yy);
      g.xy <= horz(lft.xy, v1.xy, rgt.xy);
    end
  end

endmodule

[rtl/hcd_response.sv]
// ----------------------------------------------------------------------------
// hcd_response
// determinant and trace products, scaled response compare against threshold
// ----------------------------------------------------------------------------
module hcd_response import hcd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  res_ctl_t           ctl,
  input  smooth_t            g,
  input  logic [THR25_W-1:0] thr25,
  output logic               res_valid,
  output out_item_t          res_data
);

  logic [15:0]        m_a, m_b;
  logic [17:0]        m_t;
  logic [8:0]         tr;
  res_ctl_t           c5;
  logic signed [23:0] det, det25, resp;

  assign tr = {1'b0, g.xx} + {1'b0, g.yy};

  always_ff @(posedge clk) begin
    if (adv) begin
      m_a <= 16'(g.xx) * 16'(g.yy);
      m_b <= 16'(g.xy) * 16'(g.xy);
      m_t <= 18'(tr) * 18'(tr);
    end
  end

  // 25 * det - trace^2, as shifts and adds
  always_comb begin
    det   = $signed({8'd0, m_a}) - $signed({8'd0, m_b});
    det25 = (det <<< 4) + (det <<< 3) + det;
    resp  = det25 - $signed({6'd0, m_t});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c5        <= '0;
      res_valid <= 1'b0;
    end else if (adv) begin
      c5        <= ctl;
      res_valid <= c5.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_data.is_corner    <= resp > $signed({2'b00, thr25});
      res_data.end_of_frame <= c5.eof;
    end
  end

endmodule

[rtl/harris_corner_detector_unit.sv]
// ----------------------------------------------------------------------------
// harris_corner_detector_unit
// streaming harris corner flag over raster gray pixels, one item per clock
// ----------------------------------------------------------------------------
// The block takes one item per clock and keeps that pace as long as results
// are taken: a pixel or drain item enters every cycle, its result reaches the
// two-entry output queue through the pipeline registers, and in_stall rises
// only while that queue holds two results. Each result belongs to the pixel
// 2*W+2 items back (W the used row width), so the last 2*W+2 results of a
// frame come out on drain items once the frame is complete. The state lives
// in two line memories of MAX_WIDTH entries (gray rows and gradient product
// rows), each read ahead of its write-back; no clearing pass is needed, since
// rows that are not yet written are always replaced by their reflection.
module harris_corner_detector_unit import hcd_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_write_enable,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CAW = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT + 3);
  localparam int RES_DELAY = 4;

  // configuration, kept in the form the datapath uses
  logic [THR25_W-1:0] thr25;
  logic [CAW-1:0]     wm1;     // used width minus one
  logic [RW-1:0]      hm1;     // used height minus one

  // stream position of the next item
  logic [CAW-1:0] col;
  logic [RW-1:0]  row;
  logic           full;        // whole frame received
  logic           done;        // all results of the frame given

  logic           adv, accept, is_pixel, restart, step;
  logic           last_pixel, last_step, size_write;
  logic [CAW-1:0] pos_col, xb, xo;
  logic [RW-1:0]  pos_row;
  logic [RW:0]    ya, yb, yo, hm1_x;
  win_ctl_t       a_ctl, b_ctl;
  res_ctl_t       r_ctl;
  res_ctl_t       res_q [RES_DELAY];
  prod_t          prod;
  smooth_t        g;
  logic           res_valid;
  out_item_t      res_data;

  // output queue
  out_item_t      fifo_mem [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     count;
  logic           push, pop;

  assign adv      = (count != 2'd2);
  assign in_stall = !adv;
  assign accept   = in_valid && !in_stall;
  assign is_pixel = (in_data.command == CMD_PIXEL);
  // a pixel after a complete frame starts the next one
  assign restart  = is_pixel && full;
  // a drain counts only between frame end and the last result
  assign step     = accept && (is_pixel || (full && !done));
  assign size_write = cfg_write_enable &&
                      (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  assign pos_col    = restart ? '0 : col;
  assign pos_row    = restart ? '0 : row;
  assign last_pixel = is_pixel && pos_col == wm1 && pos_row == hm1;
  // the final result comes with the item at row H+2, column 1
  assign last_step  = !is_pixel && pos_row == RW'(hm1 + RW'(3)) && pos_col == CAW'(1);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr25 <= THR25_W'(THRESHOLD_RESET * RESP_SCALE);
      wm1   <= CAW'(clamp_size(WIDTH_RESET, MAX_WIDTH) - 1);
      hm1   <= RW'(clamp_size(HEIGHT_RESET, MAX_HEIGHT) - 1);
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_THRESHOLD: thr25 <= THR25_W'(cfg_data) * THR25_W'(RESP_SCALE);
        REG_WIDTH:  wm1 <= CAW'(clamp_size(int'(cfg_data[FRAME_SIZE_W-1:0]),
                                           MAX_WIDTH) - 1);
        REG_HEIGHT: hm1 <= RW'(clamp_size(int'(cfg_data[FRAME_SIZE_W-1:0]),
                                          MAX_HEIGHT) - 1);
        default: ;
      endcase
    end
  end

  // position counters and frame flags
  always_ff @(posedge clk) begin
    if (rst || size_write) begin
      col  <= '0;
      row  <= '0;
      full <= 1'b0;
      done <= 1'b0;
    end else if (step) begin
      if (pos_col == wm1) begin
        col <= '0;
        row <= RW'(pos_row + RW'(1));
      end else begin
        col <= CAW'(pos_col + CAW'(1));
        row <= pos_row;
      end
      if (is_pixel) begin
        full <= last_pixel;
        done <= 1'b0;
      end else begin
        done <= last_step;
      end
    end
  end

  // positions one window lag (W+1 items) and two lags back
  always_comb begin
    hm1_x = {1'b0, hm1};
    ya    = {1'b0, pos_row};
    xb    = (pos_col == '0) ? wm1 : CAW'(pos_col - CAW'(1));
    yb    = (pos_col == '0) ? (ya - (RW+1)'(2)) : (ya - (RW+1)'(1));
    xo    = (xb == '0) ? wm1 : CAW'(xb - CAW'(1));
    yo    = (xb == '0) ? (yb - (RW+1)'(2)) : (yb - (RW+1)'(1));

    a_ctl.valid      = step;
    a_ctl.col_first  = (pos_col == '0);
    a_ctl.col_second = (pos_col == CAW'(1));
    a_ctl.row_top    = (ya == (RW+1)'(1));
    a_ctl.row_bottom = (ya == hm1_x + (RW+1)'(1));

    b_ctl.valid      = step;
    b_ctl.col_first  = (xb == '0);
    b_ctl.col_second = (xb == CAW'(1));
    b_ctl.row_top    = (yb == (RW+1)'(1));
    b_ctl.row_bottom = (yb == hm1_x + (RW+1)'(1));

    // negative output row: still inside the start-up lag
    r_ctl.valid = step && !yo[RW];
    r_ctl.eof   = (yo == hm1_x) && (xo == wm1);
  end

  hcd_gradient #(.MAX_WIDTH(MAX_WIDTH)) u_gradient (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .ctl   (a_ctl),
    .addr  (pos_col),
    .pixel (in_data.gray_pixel),
    .prod  (prod)
  );

  hcd_smooth #(.MAX_WIDTH(MAX_WIDTH)) u_smooth (
    .clk  (clk),
    .rst  (rst),
    .adv  (adv),
    .ctl  (b_ctl),
    .addr (xb),
    .prod (prod),
    .g    (g)
  );

  // result flags follow the datapath until the blurred values are ready
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RES_DELAY; i++) res_q[i] <= '0;
    end else if (adv) begin
      res_q[0] <= r_ctl;
      for (int i = 1; i < RES_DELAY; i++) res_q[i] <= res_q[i-1];
    end
  end

  hcd_response u_response (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .ctl       (res_q[RES_DELAY-1]),
    .g         (g),
    .thr25     (thr25),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  // two-entry output queue parts the pipeline from the consumer
  assign push      = adv && res_valid;
  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != 2'd0);
  assign out_data  = fifo_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) fifo_mem[wr_ptr] <= res_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= 2'(count + 2'(push) - 2'(pop));
    end
  end

endmodule

[rtl/hcd_checker.sv]
// ----------------------------------------------------------------------------
// hcd_checker
// port-level assertions of the harris corner detector, bound to the top level
// ----------------------------------------------------------------------------
`include "harris_corner_detector_unit_defines.svh"

module hcd_checker import hcd_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a held result stays put
  `HCD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
                   out_valid && $stable(out_data), "hcd: stalled result changed")

  // input stalls only behind waiting results
  `HCD_ASSERT_NOW(a_stall_cause, clk, rst, in_stall, out_valid,
                  "hcd: input stalled with no result waiting")

  // queue grows by at most one per cycle
  `HCD_ASSERT_NEXT(a_stall_growth, clk, rst, !out_valid, !in_stall,
                   "hcd: input stalled right after an empty queue")

endmodule

bind harris_corner_detector_unit hcd_checker u_hcd_checker (.*);

[verif/tb_harris_corner_detector_unit.sv]
// ----------------------------------------------------------------------------
// tb_harris_corner_detector_unit
// self-checking bench: pixel and drain items in, corner flags compared against
// an in-bench harris predictor, random gaps on both sides and a long out hold
// ----------------------------------------------------------------------------
module tb_harris_corner_detector_unit;
  import hcd_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SIZE_CAP    = 1024;
  localparam int QUIET_LIMIT = 5000;   // cycles without any accepted item
  localparam int SETTLE      = 24;     // pipeline depth plus output queue
  localparam int HOLD_LEN    = 300;    // long receiver hold-off

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  out_item_t out_data;
  logic cfg_write_enable = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  harris_corner_detector_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write_enable(cfg_write_enable), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // stimulus queue and expected corner flags
  in_item_t pixel_q[$];
  out_item_t corner_q[$];
  int mismatches = 0;

  // predictor state: register copies, row ring, stream position
  int unsigned thr_reg = THRESHOLD_RESET;
  int cur_w = WIDTH_RESET;
  int cur_h = HEIGHT_RESET;
  logic [7:0] row_ring [8][SIZE_CAP];
  int row_pos = 0;
  int col_pos = 0;
  int pix_seen = 0;
  int flags_out = 0;

  function automatic int clamp_dim(input int v);
    if (v < 3) return 3;
    if (v > SIZE_CAP) return SIZE_CAP;
    return v;
  endfunction

  // reflect-101 border index
  function automatic int mirror(input int i, input int n);
    int k;
    k = i;
    if (k < 0) k = -k;
    if (k >= n) k = 2 * n - 2 - k;
    if (k < 0) k = 0;
    if (k >= n) k = n - 1;
    return k;
  endfunction

  function automatic int pix(input int y, input int x);
    return int'(row_ring[mirror(y, cur_h) & 7][mirror(x, cur_w)]);
  endfunction

  function automatic int clip_abs(input int v);
    int m;
    m = (v < 0) ? -v : v;
    return (m > 255) ? 255 : m;
  endfunction

  function automatic void sobel_at(input int y, input int x, output int ix, output int iy);
    int a[3][3];
    for (int dy = 0; dy < 3; dy++)
      for (int dx = 0; dx < 3; dx++)
        a[dy][dx] = pix(y + dy - 1, x + dx - 1);
    ix = clip_abs((a[0][2] - a[0][0]) + 2 * (a[1][2] - a[1][0]) + (a[2][2] - a[2][0]));
    iy = clip_abs((a[2][0] - a[0][0]) + 2 * (a[2][1] - a[0][1]) + (a[2][2] - a[0][2]));
  endfunction

  function automatic longint smooth(input longint s);
    longint v;
    v = (s + 8) >>> 4;
    return (v > 255) ? 255 : v;
  endfunction

  // harris response test at one pixel
  function automatic logic corner_flag(input int r, input int c);
    int wt [3] = '{1, 2, 1};
    int ix, iy;
    logic [15:0] pxx, pyy, pxy;
    longint sxx, syy, sxy, gxx, gyy, gxy, det, tr;
    sxx = 0; syy = 0; sxy = 0;
    for (int dy = 0; dy < 3; dy++)
      for (int dx = 0; dx < 3; dx++) begin
        sobel_at(mirror(r + dy - 1, cur_h), mirror(c + dx - 1, cur_w), ix, iy);
        pxx = 16'(ix * ix);
        pyy = 16'(iy * iy);
        pxy = 16'(ix * iy);
        sxx += wt[dy] * wt[dx] * longint'(pxx);
        syy += wt[dy] * wt[dx] * longint'(pyy);
        sxy += wt[dy] * wt[dx] * longint'(pxy);
      end
    gxx = smooth(sxx); gyy = smooth(syy); gxy = smooth(sxy);
    det = gxx * gyy - gxy * gxy;
    tr = gxx + gyy;
    return (RESP_SCALE * det - tr * tr > RESP_SCALE * longint'(thr_reg));
  endfunction

  function automatic void restart_stream();
    row_pos = 0; col_pos = 0; pix_seen = 0; flags_out = 0;
  endfunction

  function automatic void push_flag(input int total);
    out_item_t e;
    e.is_corner = corner_flag(flags_out / cur_w, flags_out % cur_w);
    e.end_of_frame = (flags_out == total - 1);
    corner_q.push_back(e);
    flags_out++;
  endfunction

  // advance the predictor by one accepted item
  function automatic void advance_stream(input in_item_t it);
    int total, lag;
    total = cur_w * cur_h;
    lag = 2 * cur_w + 2;
    if (it.command == CMD_PIXEL) begin
      if (pix_seen >= total) restart_stream();   // pixel after a complete frame
      row_ring[row_pos & 7][col_pos] = it.gray_pixel;
      col_pos++;
      if (col_pos >= cur_w) begin
        col_pos = 0;
        row_pos++;
      end
      pix_seen++;
      if (pix_seen - 1 >= lag && flags_out < total) push_flag(total);
    end else if (pix_seen == total && flags_out < total) begin
      push_flag(total);   // drain of a held result; otherwise nothing
    end
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver: present items from the queue, with random gaps
  logic in_taken = 1'b0;
  int in_gap = 0;
  logic calm = 1'b0;   // stretches with no idling at all

  always @(posedge clk) begin
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) advance_stream(in_data);
  end

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // stalled item stays as it is
    end else if (in_gap > 0) begin
      in_valid <= 1'b0;
      in_gap <= in_gap - 1;
    end else if (pixel_q.size() > 0) begin
      in_data <= pixel_q.pop_front();
      in_valid <= 1'b1;
      in_gap <= calm ? 0 : rand_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver stall, with one long hold while the sender keeps going
  int out_gap = 0;
  int hold_left = 0;
  logic pressure_arm = 1'b0;
  logic pressure_done = 1'b0;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (pressure_arm && !pressure_done && corner_q.size() >= 2) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_LEN;
      pressure_done <= 1'b1;
    end else if (out_gap > 0) begin
      out_stall <= 1'b1;
      out_gap <= out_gap - 1;
    end else begin
      out_stall <= 1'b0;
      out_gap <= calm ? 0 : rand_gap();
    end
  end

  task automatic report(input string msg);
    $display("mismatch %s", msg);
    mismatches++;
  endtask

  // monitor: compare each result against the oldest expected flag
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      if (corner_q.size() == 0) begin
        report($sformatf("unexpected result item %b", out_data));
      end else begin
        e = corner_q.pop_front();
        if (out_data.is_corner !== e.is_corner)
          report($sformatf("is_corner: got %0b expected %0b",
                           out_data.is_corner, e.is_corner));
        if (out_data.end_of_frame !== e.end_of_frame)
          report($sformatf("end_of_frame: got %0b expected %0b",
                           out_data.end_of_frame, e.end_of_frame));
      end
    end
  end

  // watchdog on cycles with no accepted item on either side
  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 499) == 0) calm <= ~calm;
  end

  task automatic put_pixel(input logic [7:0] v);
    in_item_t it;
    it.command = CMD_PIXEL;
    it.gray_pixel = v;
    pixel_q.push_back(it);
  endtask

  task automatic put_drain();
    in_item_t it;
    it.command = CMD_DRAIN;
    it.gray_pixel = 8'($urandom_range(0, 255));
    pixel_q.push_back(it);
  endtask

  function automatic logic [7:0] rand_pixel();
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
    return $urandom_range(0, 1) ? 8'hFF : 8'h00;
  endfunction

  // wait for all items sent and all results back, then let the pipe empty
  task automatic settle();
    while (pixel_q.size() != 0 || in_valid || corner_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    case (idx)
      REG_THRESHOLD: thr_reg = val & 32'h1FFFF;
      REG_WIDTH: begin
        cur_w = clamp_dim(int'(val & 32'h7FF));
        restart_stream();
      end
      REG_HEIGHT: begin
        cur_h = clamp_dim(int'(val & 32'h7FF));
        restart_stream();
      end
      default: ;
    endcase
    @(negedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  task automatic setup(input int unsigned thr, input int unsigned w, input int unsigned h);
    settle();
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // one whole frame, optional stray drains, then some or all held results
  task automatic send_frame(input int kind, inout int pix_count);
    int total;
    total = cur_w * cur_h;
    for (int i = 0; i < total; i++) begin
      put_pixel(rand_pixel());
      pix_count++;
      if ($urandom_range(0, 19) == 0) put_drain();   // drain mid-frame: no result
    end
    if (kind < 7) repeat (2 * cur_w + 2 + $urandom_range(0, 2)) put_drain();
    else repeat ($urandom_range(0, 2 * cur_w + 1)) put_drain();   // rest dropped
  endtask

  initial begin
    int pix_count;
    int unsigned thr;
    int unsigned w_raw, h_raw;
    pix_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset sizes: a few pixels and early drains, nothing comes out
    put_pixel(8'h00); put_pixel(8'hFF); put_pixel(8'h55); put_pixel(8'hAA);
    put_drain(); put_drain();

    // smallest frame, zero threshold, extreme patterns, drain past empty
    setup(0, 3, 3);
    for (int i = 0; i < 9; i++) put_pixel((i % 2) ? 8'hFF : 8'h00);
    repeat (9) put_drain();
    for (int i = 0; i < 9; i++) put_pixel((i == 4) ? 8'hFF : 8'h00);
    put_drain();
    put_pixel(8'h80);   // new frame drops the held results
    settle();
    write_reg(REG_UNUSED, 17'h1FFFF);   // out-of-range index: ignored

    // sizes above the maximum, frame cut short by the next size write
    setup(17'h1FFFF, 2047, 2047);
    repeat (150) put_pixel(rand_pixel());
    put_drain();

    // wide row, height below the minimum, full threshold field
    setup(17'h1FFFF, 100, 0);
    pressure_arm = 1'b1;
    send_frame(0, pix_count);

    // narrowest row below minimum, tall frame
    setup(70000, 2, 60);
    send_frame(0, pix_count);

    // random frames of small sizes
    pix_count = 0;
    while (pix_count < 500) begin
      case ($urandom_range(0, 2))
        0: thr = 0;
        1: thr = $urandom_range(0, 2000);
        default: thr = $urandom_range(0, 70000);
      endcase
      w_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 10);
      h_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
      setup(thr, w_raw, h_raw);
      if ($urandom_range(0, 4) == 0) begin
        // partial frame, cut short by the next size write
        repeat ($urandom_range(1, cur_w * cur_h - 1)) begin
          put_pixel(rand_pixel());
          pix_count++;
        end
        put_drain();
      end else begin
        repeat ($urandom_range(1, 3)) send_frame($urandom_range(0, 9), pix_count);
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
